/* rtl/core/emb_pkg.sv */
// Shared types, constants and the per-channel emboss arithmetic of the emboss core.
// Used by every module of the core and by the channel interfaces; depends on nothing.
package emb_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;
	localparam int XW          = $clog2(MAX_WIDTH);
	localparam int CFG_W       = 11;
	localparam int CMP_W       = ((XW > CFG_W) ? XW : CFG_W) + 1;
	localparam int CFG_IDX_W   = 2;
	localparam int CHAN_W      = 8;
	localparam int PIX_W       = 3 * CHAN_W;
	localparam int BIAS        = 128;
	localparam int CHAN_MAX    = 255;
	localparam int WIDTH_RESET = (MAX_WIDTH < 512) ? MAX_WIDTH : 512;
	localparam int HEIGHT_RESET = 512;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_FLUSH = 1'b1;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pix_t;

	// one window column, index 0 is the top row
	typedef pix_t [2:0] col_t;

	typedef struct packed {
		logic emit;
		logic mask_top;
		logic mask_bot;
		logic mask_left;
		logic mask_right;
		logic last;
	} flags_t;

	typedef struct packed {
		logic          valid;
		logic          use_pix;
		logic [XW-1:0] col;
		flags_t        flags;
	} adv_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              last;
	} res_t;

	// bias + right/bottom taps - left/top taps, clamped to one channel
	function automatic logic [CHAN_W-1:0] filt(
		input logic [CHAN_W-1:0] a00,
		input logic [CHAN_W-1:0] a01,
		input logic [CHAN_W-1:0] a10,
		input logic [CHAN_W-1:0] a12,
		input logic [CHAN_W-1:0] a21,
		input logic [CHAN_W-1:0] a22
	);
		logic [CHAN_W+1:0]        pos;
		logic [CHAN_W+1:0]        neg;
		logic signed [CHAN_W+2:0] s;
		logic [CHAN_W-1:0]        res;
		pos = (CHAN_W+2)'(BIAS) + (CHAN_W+2)'(a12) + (CHAN_W+2)'(a21) + (CHAN_W+2)'(a22);
		neg = (CHAN_W+2)'(a00) + (CHAN_W+2)'(a01) + (CHAN_W+2)'(a10);
		s = $signed({1'b0, pos}) - $signed({1'b0, neg});
		if (s < 0) begin
			res = '0;
		end else if (s > $signed((CHAN_W+3)'(CHAN_MAX))) begin
			res = CHAN_W'(CHAN_MAX);
		end else begin
			res = s[CHAN_W-1:0];
		end
		return res;
	endfunction

endpackage

/* rtl/core/emb_if.sv */
// Channel interfaces of the emboss core: pixel requests, results and register writes.
// Depends on emb_pkg for field widths.
interface emb_pix_if;
	logic                       valid;
	logic                       ready;
	logic                       req_type;
	logic [emb_pkg::CHAN_W-1:0] red_in;
	logic [emb_pkg::CHAN_W-1:0] green_in;
	logic [emb_pkg::CHAN_W-1:0] blue_in;

	modport source (output valid, req_type, red_in, green_in, blue_in, input ready);
	modport sink (input valid, req_type, red_in, green_in, blue_in, output ready);
endinterface

interface emb_res_if;
	logic                       valid;
	logic                       ready;
	logic [emb_pkg::CHAN_W-1:0] red_out;
	logic [emb_pkg::CHAN_W-1:0] green_out;
	logic [emb_pkg::CHAN_W-1:0] blue_out;
	logic                       frame_last;

	modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
	modport sink (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

interface emb_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [emb_pkg::CFG_IDX_W-1:0] index;
	logic [emb_pkg::CFG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/emb_ctrl.sv */
// Frame position tracking, register file and per-request decisions of the emboss core.
// Depends on emb_pkg.
module emb_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr,
	input  logic [emb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [emb_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic                          req_type,
	output logic                          in_ready,
	output emb_pkg::adv_t                 adv
);

	logic [emb_pkg::CFG_W-1:0] w_q, h_q, y_q;
	logic [emb_pkg::XW-1:0]    x_q;
	logic                      bubble_q;

	logic                      accept, is_pix, row_in, x_zero, emit, go, col_wrap;
	logic [emb_pkg::CFG_W-1:0] r, cfg_v;
	logic [emb_pkg::CMP_W-1:0] x_ext, w_ext, h_ext, r_ext, c;
	emb_pkg::flags_t           flags;

	always_comb begin
		in_ready = en && !bubble_q;
		accept   = in_valid && in_ready;
		is_pix   = (req_type == emb_pkg::REQ_PIXEL);
		row_in   = (y_q < h_q);
		x_ext    = emb_pkg::CMP_W'(x_q);
		w_ext    = emb_pkg::CMP_W'(w_q);
		h_ext    = emb_pkg::CMP_W'(h_q);
		x_zero   = (x_q == '0);
		// output lags the stream by one row plus one pixel
		emit     = (y_q >= emb_pkg::CFG_W'(2)) || ((y_q == emb_pkg::CFG_W'(1)) && !x_zero);
		go       = (accept && ((is_pix && row_in) || (!is_pix && !row_in))) || (bubble_q && en);
		r        = x_zero ? y_q - emb_pkg::CFG_W'(2) : y_q - emb_pkg::CFG_W'(1);
		r_ext    = emb_pkg::CMP_W'(r);
		c        = x_zero ? w_ext - emb_pkg::CMP_W'(1) : x_ext - emb_pkg::CMP_W'(1);
		col_wrap = (x_ext + emb_pkg::CMP_W'(1)) >= w_ext;

		flags.emit       = emit;
		flags.mask_top   = (r == '0);
		flags.mask_bot   = (r_ext + emb_pkg::CMP_W'(1)) >= h_ext;
		flags.mask_left  = (c == '0);
		flags.mask_right = (c + emb_pkg::CMP_W'(1)) >= w_ext;
		flags.last       = emit && ((r_ext + emb_pkg::CMP_W'(1)) == h_ext)
			&& ((c + emb_pkg::CMP_W'(1)) == w_ext);

		adv.valid   = go;
		adv.use_pix = !bubble_q && is_pix;
		adv.col     = x_q;
		adv.flags   = flags;

		cfg_v = (cfg_data == '0) ? emb_pkg::CFG_W'(1) : cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q      <= emb_pkg::CFG_W'(emb_pkg::WIDTH_RESET);
			h_q      <= emb_pkg::CFG_W'(emb_pkg::HEIGHT_RESET);
			x_q      <= '0;
			y_q      <= '0;
			bubble_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_index)
					emb_pkg::REG_FRAME_WIDTH: begin
						w_q <= (emb_pkg::CMP_W'(cfg_v) > emb_pkg::CMP_W'(emb_pkg::MAX_WIDTH))
							? emb_pkg::CFG_W'(emb_pkg::MAX_WIDTH) : cfg_v;
						x_q <= '0;
						y_q <= '0;
					end
					emb_pkg::REG_FRAME_HEIGHT: begin
						h_q <= (emb_pkg::CMP_W'(cfg_v) > emb_pkg::CMP_W'(emb_pkg::MAX_HEIGHT))
							? emb_pkg::CFG_W'(emb_pkg::MAX_HEIGHT) : cfg_v;
						x_q <= '0;
						y_q <= '0;
					end
					default: begin
					end
				endcase
			end else if (go) begin
				if (flags.last) begin
					x_q <= '0;
					y_q <= '0;
				end else if (col_wrap) begin
					x_q <= '0;
					y_q <= y_q + emb_pkg::CFG_W'(1);
				end else begin
					x_q <= x_q + emb_pkg::XW'(1);
				end
			end
			// a flush that lands on the silent position of a one-row frame takes a second step
			if (en) begin
				bubble_q <= accept && !is_pix && !row_in && !emit;
			end
		end
	end

endmodule

/* rtl/core/emb_line_buf.sv */
// Two line stores of the emboss core, kept side by side in one single-port-write memory.
// Registered read with forwarding of the previous write. Depends on emb_pkg.
module emb_line_buf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   rd,
	input  logic [emb_pkg::XW-1:0] rd_addr,
	input  logic                   wr,
	input  logic [emb_pkg::XW-1:0] wr_addr,
	input  emb_pkg::pix_t          pix,
	output emb_pkg::pix_t          upper,
	output emb_pkg::pix_t          middle
);

	logic [2*emb_pkg::PIX_W-1:0] mem [emb_pkg::MAX_WIDTH];
	logic [2*emb_pkg::PIX_W-1:0] rd_q, fwd_data_q, rd_word, wr_word;
	logic                        fwd_q;

	always_comb begin
		rd_word = fwd_q ? fwd_data_q : rd_q;
		upper   = rd_word[2*emb_pkg::PIX_W-1:emb_pkg::PIX_W];
		middle  = rd_word[emb_pkg::PIX_W-1:0];
		// middle row moves up, new pixel becomes the middle row
		wr_word = {middle, pix};
	end

	always_ff @(posedge clk) begin
		if (en && wr) begin
			mem[wr_addr] <= wr_word;
		end
		if (en && rd) begin
			rd_q       <= mem[rd_addr];
			fwd_data_q <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (en && rd) begin
			fwd_q <= wr && (wr_addr == rd_addr);
		end
	end

endmodule

/* rtl/core/emb_win_cell.sv */
// One column cell of the 3x3 window chain: holds three pixels, hands them to its neighbor.
// Depends on emb_pkg.
module emb_win_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift,
	input  emb_pkg::col_t col_in,
	output emb_pkg::col_t col_out
);

	emb_pkg::col_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

endmodule

/* rtl/core/emb_kernel.sv */
// Emboss kernel of the core: edge masking of the window and the clamped sum per channel.
// Depends on emb_pkg.
module emb_kernel (
	input  emb_pkg::col_t   win0,
	input  emb_pkg::col_t   win1,
	input  emb_pkg::col_t   win2,
	input  emb_pkg::flags_t flags,
	output emb_pkg::pix_t   result
);

	emb_pkg::pix_t nb [3][3];
	emb_pkg::col_t cols [3];

	always_comb begin
		cols[0] = win0;
		cols[1] = win1;
		cols[2] = win2;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				nb[i][j] = cols[j][i];
				// drop neighbors that fall outside the frame
				if ((i == 0 && flags.mask_top) || (i == 2 && flags.mask_bot)
						|| (j == 0 && flags.mask_left) || (j == 2 && flags.mask_right)) begin
					nb[i][j] = '0;
				end
			end
		end
		result.red   = emb_pkg::filt(nb[0][0].red, nb[0][1].red, nb[1][0].red,
			nb[1][2].red, nb[2][1].red, nb[2][2].red);
		result.green = emb_pkg::filt(nb[0][0].green, nb[0][1].green, nb[1][0].green,
			nb[1][2].green, nb[2][1].green, nb[2][2].green);
		result.blue  = emb_pkg::filt(nb[0][0].blue, nb[0][1].blue, nb[1][0].blue,
			nb[1][2].blue, nb[2][1].blue, nb[2][2].blue);
	end

endmodule

/* rtl/core/emboss_3x3_rgb_filter_core.sv */
// Top level of the 3x3 RGB emboss core: pipeline, window cell chain and result skid stage.
// Depends on emb_pkg, emb_if, emb_ctrl, emb_line_buf, emb_win_cell and emb_kernel.
//
//   port  dir   carries
//   pix   in    pixel or flush request: req_type, red_in, green_in, blue_in
//   res   out   embossed pixel: red_out, green_out, blue_out, frame_last
//   cfg   in    register write: index, data (0 = frame_width, 1 = frame_height)
//
// One request per cycle unless held; a result is registered in stage 1, stage 2 and the output register.
// The first flush of a one-row frame also steps over one silent position before the next request.
// The line store memory has one write and one read port; no clearing pass after reset.
// A stalled result moves to a skid register and the pipeline holds while that register is full.
// Register writes are always ready and restart the frame position.
module emboss_3x3_rgb_filter_core (
	input  logic clk,
	input  logic arst_n,
	emb_pix_if.sink   pix,
	emb_res_if.source res,
	emb_cfg_if.sink   cfg
);

	logic                   en;
	emb_pkg::adv_t          adv;
	emb_pkg::pix_t          pix_s0;

	logic                   valid_s1, valid_s2;
	logic [emb_pkg::XW-1:0] col_s1;
	emb_pkg::pix_t          pix_s1;
	emb_pkg::flags_t        flags_s1, flags_s2;

	emb_pkg::pix_t          upper, middle, result;
	emb_pkg::col_t          col_in;
	emb_pkg::col_t          win [3];

	emb_pkg::res_t          out_q, skid_q, res_new;
	logic                   out_valid_q, skid_valid_q, push, take;

	assign en        = !skid_valid_q;
	assign cfg.ready = 1'b1;

	emb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg.valid && cfg.ready),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.en        (en),
		.in_valid  (pix.valid),
		.req_type  (pix.req_type),
		.in_ready  (pix.ready),
		.adv       (adv)
	);

	always_comb begin
		pix_s0 = '0;
		if (adv.use_pix) begin
			pix_s0.red   = pix.red_in;
			pix_s0.green = pix.green_in;
			pix_s0.blue  = pix.blue_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= adv.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (adv.valid) begin
				col_s1   <= adv.col;
				pix_s1   <= pix_s0;
				flags_s1 <= adv.flags;
			end
			flags_s2 <= flags_s1;
		end
	end

	emb_line_buf u_line_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.rd      (adv.valid),
		.rd_addr (adv.col),
		.wr      (valid_s1),
		.wr_addr (col_s1),
		.pix     (pix_s1),
		.upper   (upper),
		.middle  (middle)
	);

	always_comb begin
		col_in[0] = upper;
		col_in[1] = middle;
		col_in[2] = pix_s1;
	end

	// newest column enters cell 2 and walks down to cell 0
	for (genvar j = 0; j < 3; j++) begin : g_cell
		emb_win_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (en && valid_s1),
			.col_in  ((j == 2) ? col_in : win[(j + 1) % 3]),
			.col_out (win[j])
		);
	end

	emb_kernel u_kernel (
		.win0   (win[0]),
		.win1   (win[1]),
		.win2   (win[2]),
		.flags  (flags_s2),
		.result (result)
	);

	always_comb begin
		res_new.red   = result.red;
		res_new.green = result.green;
		res_new.blue  = result.blue;
		res_new.last  = flags_s2.last;
		push          = en && valid_s2 && flags_s2.emit;
		take          = out_valid_q && res.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || take) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= res_new;
			end
		end else if (push) begin
			skid_q <= res_new;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.red_out    = out_q.red;
	assign res.green_out  = out_q.green;
	assign res.blue_out   = out_q.blue;
	assign res.frame_last = out_q.last;

endmodule
